// ===== sv/tgarle_pkg.sv =====
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; imported by tgarle_ctrl, tgarle_dp and the top level.
`default_nettype none
package tgarle_pkg;

  // Default sizes
  localparam int MAX_BPP_DEF   = 4;
  localparam int PIX_CNT_W_DEF = 24;

  // Configuration port
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int BPP_W      = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT     = 1'd1;
  localparam logic [BPP_W-1:0]     BPP_RESET           = 3'd3;
  localparam int                   PIX_CNT_RESET       = 1;

  // Packet header decode
  localparam int BYTE_W = 8;
  localparam int LEFT_W = 8;
  localparam logic [BYTE_W-1:0] RUN_THRESHOLD = 8'd128;
  localparam logic [BYTE_W-1:0] RUN_BIAS      = 8'd127;

  // Result fields
  localparam int PIXEL_W = 32;
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_OVERFLOW = 2'd1;
  localparam status_t STATUS_IGNORED  = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_HEADER,
    ST_PIXEL,
    ST_EMIT,
    ST_DONE,
    ST_ERROR
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;        // frame start: clear pixel counter
    logic load_header;  // take a packet header byte
    logic load_byte;    // take a pixel byte
    logic emit;         // build one pixel result
    logic ignore;       // build one ignored-byte result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;        // output register can take a result
    logic pixel_complete;  // current byte completes a pixel
    logic emit_err;        // this result hit overflow
    logic emit_last;       // this result ends the burst
    logic pkt_end;         // packet ends with this result
    logic at_limit;        // image pixel count reached
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== sv/tgarle_ctrl.sv =====
// Controller FSM for the TGA RLE decoder: sequences header, pixel,
// burst emit and done/error phases. Depends on tgarle_pkg.
`default_nettype none
module tgarle_ctrl
  import tgarle_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_frame_start,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    logic   accept;
    state_t eff;
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r != ST_EMIT) && sts.out_free;
    accept    = in_valid && in_ready;
    eff       = in_frame_start ? ST_HEADER : state_r;
    if (state_r == ST_EMIT) begin
      if (sts.out_free) begin
        cmd.emit = 1'b1;
        if (sts.emit_err) begin
          state_nxt = ST_ERROR;
        end else if (sts.emit_last) begin
          if (!sts.pkt_end) begin
            state_nxt = ST_PIXEL;
          end else if (sts.at_limit) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_HEADER;
          end
        end
      end
    end else if (accept) begin
      cmd.clear = in_frame_start;
      unique case (eff)
        ST_HEADER: begin
          cmd.load_header = 1'b1;
          state_nxt       = ST_PIXEL;
        end
        ST_PIXEL: begin
          cmd.load_byte = 1'b1;
          if (sts.pixel_complete) begin
            state_nxt = ST_EMIT;
          end
        end
        ST_DONE, ST_ERROR: begin
          cmd.ignore = 1'b1;
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/tgarle_dp.sv =====
// Datapath for the TGA RLE decoder: pixel assembly, packet and image
// counters, result formation and the output register. Depends on tgarle_pkg.
`default_nettype none
module tgarle_dp
  import tgarle_pkg::*;
#(
  parameter int MAX_BYTES_PER_PIXEL = MAX_BPP_DEF,
  parameter int PIXEL_COUNT_WIDTH   = PIX_CNT_W_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [BYTE_W-1:0]      in_byte,
  input  wire logic [BPP_W-1:0]       bpp_cfg,
  input  wire logic [PIXEL_COUNT_WIDTH-1:0] limit,
  input  wire dp_cmd_t                cmd,
  output dp_sts_t                     sts,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [PIXEL_W-1:0]          out_pixel_first,
  output logic [PIXEL_W-1:0]          out_pixel_second,
  output logic [1:0]                  out_pixels_valid,
  output logic                        out_run_last,
  output logic                        out_image_done,
  output status_t                     out_status
);

  localparam int MAXB  = MAX_BYTES_PER_PIXEL;
  localparam int IDX_W = (MAXB > 1) ? $clog2(MAXB) : 1;
  localparam int PCW   = PIXEL_COUNT_WIDTH;

  logic [MAXB-1:0][BYTE_W-1:0] color_r, color_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [LEFT_W-1:0]           left_r, left_nxt;
  logic [LEFT_W-1:0]           rem_r, rem_nxt;
  logic                        is_run_r, is_run_nxt;
  logic [PCW-1:0]              dec_r, dec_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0]          first_r, first_nxt;
  logic [PIXEL_W-1:0]          second_r, second_nxt;
  logic [1:0]                  pv_r, pv_nxt;
  logic                        last_r, last_nxt;
  logic                        done_r, done_nxt;
  status_t                     stat_r, stat_nxt;

  // Effective pixel size, clamped to 1..MAXB
  logic [BPP_W-1:0] eff_bpp;
  always_comb begin
    if (bpp_cfg == '0) begin
      eff_bpp = BPP_W'(1);
    end else if (bpp_cfg > BPP_W'(MAXB)) begin
      eff_bpp = BPP_W'(MAXB);
    end else begin
      eff_bpp = bpp_cfg;
    end
  end

  // Burst step arithmetic
  logic [PCW-1:0] dec_a, dec_b;
  logic           ovf_a, done_a, done_b, two;
  assign ovf_a  = (dec_r >= limit);
  assign dec_a  = dec_r + PCW'(1);
  assign done_a = (dec_a == limit);
  assign dec_b  = dec_a + PCW'(1);
  assign done_b = (dec_b == limit);
  assign two    = (rem_r != LEFT_W'(1));

  logic [PIXEL_W-1:0] color_word;
  assign color_word = PIXEL_W'(color_r);

  // Status to the controller
  always_comb begin
    sts                = '0;
    sts.out_free       = !out_valid_r || out_ready;
    sts.pixel_complete = ((BPP_W'(idx_r) + BPP_W'(1)) >= eff_bpp);
    if (ovf_a) begin
      sts.emit_err  = 1'b1;
      sts.emit_last = 1'b1;
    end else if (!two) begin
      sts.emit_last = 1'b1;
      sts.pkt_end   = (left_r == LEFT_W'(1));
      sts.at_limit  = done_a;
    end else if (done_a) begin
      sts.emit_err  = 1'b1;
      sts.emit_last = 1'b1;
    end else begin
      sts.emit_last = (rem_r == LEFT_W'(2));
      sts.pkt_end   = (left_r == LEFT_W'(2));
      sts.at_limit  = done_b;
    end
  end

  // Next-state logic
  always_comb begin
    color_nxt     = color_r;
    idx_nxt       = idx_r;
    left_nxt      = left_r;
    rem_nxt       = rem_r;
    is_run_nxt    = is_run_r;
    dec_nxt       = dec_r;
    out_valid_nxt = out_valid_r && !out_ready;
    first_nxt     = first_r;
    second_nxt    = second_r;
    pv_nxt        = pv_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    stat_nxt      = stat_r;

    if (cmd.clear) begin
      dec_nxt = '0;
    end

    // Packet header
    if (cmd.load_header) begin
      idx_nxt = '0;
      if (in_byte < RUN_THRESHOLD) begin
        left_nxt   = LEFT_W'(in_byte + BYTE_W'(1));
        is_run_nxt = 1'b0;
      end else begin
        left_nxt   = LEFT_W'(in_byte - RUN_BIAS);
        is_run_nxt = 1'b1;
      end
    end

    // Pixel byte: lane idx takes the byte, higher lanes clear on a new pixel
    if (cmd.load_byte) begin
      for (int k = 0; k < MAXB; k++) begin
        if (IDX_W'(k) == idx_r) begin
          color_nxt[k] = in_byte;
        end else if (idx_r == '0) begin
          color_nxt[k] = '0;
        end
      end
      if (sts.pixel_complete) begin
        idx_nxt = '0;
        rem_nxt = is_run_r ? left_r : LEFT_W'(1);
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end

    // One result of a burst
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      second_nxt    = '0;
      done_nxt      = 1'b0;
      stat_nxt      = STATUS_OK;
      last_nxt      = sts.emit_last;
      if (ovf_a) begin
        first_nxt = '0;
        pv_nxt    = 2'd0;
        stat_nxt  = STATUS_OVERFLOW;
      end else if (!two) begin
        first_nxt = color_word;
        pv_nxt    = 2'd1;
        done_nxt  = done_a;
        dec_nxt   = dec_a;
        rem_nxt   = rem_r - LEFT_W'(1);
        left_nxt  = left_r - LEFT_W'(1);
      end else if (done_a) begin
        first_nxt = color_word;
        pv_nxt    = 2'd1;
        done_nxt  = 1'b1;
        stat_nxt  = STATUS_OVERFLOW;
        dec_nxt   = dec_a;
      end else begin
        first_nxt  = color_word;
        second_nxt = color_word;
        pv_nxt     = 2'd2;
        done_nxt   = done_b;
        dec_nxt    = dec_b;
        rem_nxt    = rem_r - LEFT_W'(2);
        left_nxt   = left_r - LEFT_W'(2);
      end
    end

    // Byte ignored after image end or error
    if (cmd.ignore) begin
      out_valid_nxt = 1'b1;
      first_nxt     = '0;
      second_nxt    = '0;
      pv_nxt        = 2'd0;
      last_nxt      = 1'b1;
      done_nxt      = 1'b0;
      stat_nxt      = STATUS_IGNORED;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      left_r      <= '0;
      rem_r       <= '0;
      is_run_r    <= 1'b0;
      dec_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      left_r      <= left_nxt;
      rem_r       <= rem_nxt;
      is_run_r    <= is_run_nxt;
      dec_r       <= dec_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    color_r  <= color_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
    pv_r     <= pv_nxt;
    last_r   <= last_nxt;
    done_r   <= done_nxt;
    stat_r   <= stat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_first  = first_r;
  assign out_pixel_second = second_r;
  assign out_pixels_valid = pv_r;
  assign out_run_last     = last_r;
  assign out_image_done   = done_r;
  assign out_status       = stat_r;

endmodule
`default_nettype wire

// ===== sv/tga_rle_pixel_decoder_top.sv =====
// TGA RLE pixel decoder top: config registers, controller and datapath.
// A byte that completes a pixel sends the controller to the emit phase, which
// builds its N results (1 raw, up to 64 for a run of 128) in the output register
// one per cycle while that register is free; input is not ready until the burst
// ends. Header and other pixel bytes are taken while the output register is free.
// Synchronous active-low reset: bytes_per_pixel=3, pixel_count=1, header phase.
`default_nettype none
module tga_rle_pixel_decoder_top
  import tgarle_pkg::*;
#(
  parameter int MAX_BYTES_PER_PIXEL = MAX_BPP_DEF,
  parameter int PIXEL_COUNT_WIDTH   = PIX_CNT_W_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input requests
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     in_byte,
  input  wire logic                  in_frame_start,
  // Result requests
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIXEL_W-1:0]         out_pixel_first,
  output logic [PIXEL_W-1:0]         out_pixel_second,
  output logic [1:0]                 out_pixels_valid,
  output logic                       out_run_last,
  output logic                       out_image_done,
  output status_t                    out_status
);

  logic [BPP_W-1:0]             bpp_r;
  logic [PIXEL_COUNT_WIDTH-1:0] pix_cnt_r;
  dp_cmd_t                      cmd;
  dp_sts_t                      sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r     <= BPP_RESET;
      pix_cnt_r <= PIXEL_COUNT_WIDTH'(PIX_CNT_RESET);
    end else if (cfg_we) begin
      if (cfg_index == REG_BYTES_PER_PIXEL) begin
        bpp_r <= cfg_wdata[BPP_W-1:0];
      end else if (cfg_index == REG_PIXEL_COUNT) begin
        pix_cnt_r <= PIXEL_COUNT_WIDTH'(cfg_wdata);
      end
    end
  end

  tgarle_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_frame_start (in_frame_start),
    .in_ready       (in_ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  tgarle_dp #(
    .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL),
    .PIXEL_COUNT_WIDTH   (PIXEL_COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_byte          (in_byte),
    .bpp_cfg          (bpp_r),
    .limit            (pix_cnt_r),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_pixel_first  (out_pixel_first),
    .out_pixel_second (out_pixel_second),
    .out_pixels_valid (out_pixels_valid),
    .out_run_last     (out_run_last),
    .out_image_done   (out_image_done),
    .out_status       (out_status)
  );

endmodule
`default_nettype wire

// ===== bench/tga_rle_sb_pkg.sv =====
`timescale 1ns / 1ps
// Pixel scoreboard for the TGA RLE decoder bench: a byte-level decoder model
// and the queue of pixel results it predicts. Depends on tgarle_pkg.
package tga_rle_sb_pkg;
  import tgarle_pkg::*;

  // One result request as it leaves the decoder
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_first;
    logic [PIXEL_W-1:0] pixel_second;
    logic [1:0]         pixels_valid;
    logic               run_last;
    logic               image_done;
    status_t            status;
  } pixel_result_t;

  typedef enum logic [2:0] {
    DEC_HEADER,
    DEC_RAW,
    DEC_RUN,
    DEC_DONE,
    DEC_ERROR
  } decode_phase_e;

  class pixel_scoreboard;
    // Register copies
    logic [BPP_W-1:0]         bpp_reg;
    logic [PIX_CNT_W_DEF-1:0] count_reg;
    // Decoder state
    decode_phase_e            phase;
    logic [LEFT_W-1:0]        pixels_left;
    logic [1:0]               byte_idx;
    logic [PIXEL_W-1:0]       color;
    logic [PIX_CNT_W_DEF-1:0] decoded;
    pixel_result_t            awaited_results[$];
    int unsigned              errors;

    function new();
      bpp_reg     = BPP_RESET;
      count_reg   = PIX_CNT_RESET;
      phase       = DEC_HEADER;
      pixels_left = '0;
      byte_idx    = '0;
      color       = '0;
      decoded     = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_BYTES_PER_PIXEL) begin
        bpp_reg = data[BPP_W-1:0];
      end else begin
        count_reg = data[PIX_CNT_W_DEF-1:0];
      end
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    // Emit n copies of the buffered pixel, two per result, stopping at overflow
    function void emit_pixel_copies(int unsigned n);
      pixel_result_t burst[$];
      pixel_result_t r;
      bit            open;
      bit            overflow;
      r        = '0;
      open     = 1'b0;
      overflow = 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
        if (decoded >= count_reg) begin
          if (!open) r = '0;
          r.status = STATUS_OVERFLOW;
          open     = 1'b1;
          overflow = 1'b1;
          break;
        end
        decoded = decoded + 1'b1;
        if (!open) begin
          r              = '0;
          r.pixel_first  = color;
          r.pixels_valid = 2'd1;
          open           = 1'b1;
        end else begin
          r.pixel_second = color;
          r.pixels_valid = 2'd2;
          open           = 1'b0;
        end
        if (decoded == count_reg) r.image_done = 1'b1;
        if (!open) burst.push_back(r);
      end
      if (open) burst.push_back(r);

      if (overflow) begin
        phase = DEC_ERROR;
      end else begin
        pixels_left = pixels_left - LEFT_W'(n);
        if (pixels_left == 0) phase = (decoded >= count_reg) ? DEC_DONE : DEC_HEADER;
      end

      if (burst.size() > 0) begin
        burst[burst.size()-1].run_last = 1'b1;
        foreach (burst[k]) awaited_results.push_back(burst[k]);
      end
    endfunction

    // Accepted input request; returns 0 when the byte is only ignored
    function bit decode_byte(logic [BYTE_W-1:0] data, logic frame_start);
      int unsigned   size;
      pixel_result_t ignored;
      if (frame_start) begin
        phase       = DEC_HEADER;
        pixels_left = '0;
        byte_idx    = '0;
        color       = '0;
        decoded     = '0;
      end
      case (phase)
        DEC_HEADER: begin
          if (data < RUN_THRESHOLD) begin
            pixels_left = data + 8'd1;
            phase       = DEC_RAW;
          end else begin
            pixels_left = data - RUN_BIAS;
            phase       = DEC_RUN;
          end
          byte_idx = '0;
          return 1'b1;
        end
        DEC_RAW, DEC_RUN: begin
          // out-of-range sizes clamp into 1..max
          size = (bpp_reg == 0) ? 1 :
                 ((bpp_reg > MAX_BPP_DEF) ? MAX_BPP_DEF : int'(bpp_reg));
          if (byte_idx == 0) color = '0;
          color = color | (PIXEL_W'(data) << (8 * byte_idx));
          if (byte_idx + 1 < size) begin
            byte_idx = byte_idx + 1'b1;
            return 1'b1;
          end
          byte_idx = '0;
          emit_pixel_copies((phase == DEC_RAW) ? 1 : int'(pixels_left));
          return 1'b1;
        end
        default: begin
          ignored          = '0;
          ignored.run_last = 1'b1;
          ignored.status   = STATUS_IGNORED;
          awaited_results.push_back(ignored);
          return 1'b0;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [PIXEL_W-1:0] want,
                                logic [PIXEL_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Accepted result request against the oldest prediction
    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with nothing pending: pixels_valid %0d status %0d",
               got.pixels_valid, got.status);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("pixel_first", want.pixel_first, got.pixel_first);
      compare_field("pixel_second", want.pixel_second, got.pixel_second);
      compare_field("pixels_valid", PIXEL_W'(want.pixels_valid), PIXEL_W'(got.pixels_valid));
      compare_field("run_last", PIXEL_W'(want.run_last), PIXEL_W'(got.run_last));
      compare_field("image_done", PIXEL_W'(want.image_done), PIXEL_W'(got.image_done));
      compare_field("status", PIXEL_W'(want.status), PIXEL_W'(got.status));
    endfunction
  endclass

endpackage

// ===== bench/tb_tga_rle_pixel_decoder_top.sv =====
`timescale 1ns / 1ps
// Bench top for tga_rle_pixel_decoder_top: directed packets, then random images
// under bursty input and a stalling receiver. Depends on tgarle_pkg, tga_rle_sb_pkg.
module tb_tga_rle_pixel_decoder_top;
  import tgarle_pkg::*;
  import tga_rle_sb_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 450;
  localparam int IMAGE_CAP       = 40;
  localparam int CYCLE_LIMIT     = 2_000_000;

  typedef enum int {IMG_CLEAN, IMG_OVERFLOW, IMG_TRUNCATED, IMG_TRAILING} image_shape_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_style_e;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_byte        = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [PIXEL_W-1:0]    out_pixel_first;
  logic [PIXEL_W-1:0]    out_pixel_second;
  logic [1:0]            out_pixels_valid;
  logic                  out_run_last;
  logic                  out_image_done;
  status_t               out_status;

  pixel_scoreboard sb;
  int unsigned     decoded_items = 0;
  int unsigned     cycle_count   = 0;
  int unsigned     burst_left    = 0;
  int unsigned     hold_requests = 0;
  int unsigned     holds_served  = 0;
  int unsigned     hold_left     = 0;
  int unsigned     style_left    = 0;
  int unsigned     rx_tick       = 0;
  rx_style_e       rx_style      = RX_OPEN;

  tga_rle_pixel_decoder_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_first  (out_pixel_first),
    .out_pixel_second (out_pixel_second),
    .out_pixels_valid (out_pixels_valid),
    .out_run_last     (out_run_last),
    .out_image_done   (out_image_done),
    .out_status       (out_status)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tga_rle_pixel_decoder_top verification failed");
      $finish;
    end
  end

  // Monitor: input side noted before result side in the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (sb.decode_byte(in_byte, in_frame_start)) decoded_items++;
      end
      if (out_valid && out_ready) begin
        sb.check_result('{out_pixel_first, out_pixel_second, out_pixels_valid,
                          out_run_last, out_image_done, out_status});
      end
    end
  end

  // Receiver: long hold-off on request, otherwise changing stall styles
  always @(negedge clk) begin
    rx_tick++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        rx_style   = rx_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(8, 80);
      end
      style_left--;
      case (rx_style)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ((rx_tick % 4) < 2);
      endcase
    end
  end

  // One input request; returns at the edge that accepts it
  task automatic push_byte(input logic [BYTE_W-1:0] data, input logic frame_start);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_byte        <= data;
    in_frame_start <= frame_start;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait for every predicted result
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(input logic [BPP_W-1:0] bpp,
                              input logic [CFG_DATA_W-1:0] count);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= REG_BYTES_PER_PIXEL;
    cfg_wdata <= CFG_DATA_W'(bpp);
    @(negedge clk);
    cfg_index <= REG_PIXEL_COUNT;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'(bpp));
    sb.write_reg(REG_PIXEL_COUNT, count);
  endtask

  // Header plus pixel bytes; raw or run picked at random
  task automatic send_packet(input int unsigned npix, input int unsigned eff,
                             input logic frame_start);
    bit          is_run;
    int unsigned copies;
    is_run = 1'($urandom_range(0, 1));
    push_byte(is_run ? (BYTE_W'(npix) + RUN_BIAS) : BYTE_W'(npix - 1), frame_start);
    copies = is_run ? 1 : npix;
    repeat (copies * eff) push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
  endtask

  // Mostly complete images; some overflow, get cut short or carry stray bytes
  task automatic send_image(input int unsigned total, input int unsigned eff);
    image_shape_e shape;
    int unsigned  pick;
    int unsigned  remaining;
    int unsigned  size;
    logic         first;
    pick      = $urandom_range(0, 9);
    shape     = (pick < 7) ? IMG_CLEAN : image_shape_e'(pick - 6);
    remaining = total;
    if (remaining == 0) remaining = $urandom_range(1, 3);
    else if (remaining > IMAGE_CAP) remaining = $urandom_range(1, IMAGE_CAP);
    if (shape == IMG_TRUNCATED) remaining = $urandom_range(0, remaining - 1);
    first = 1'b1;
    while (remaining != 0) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
      if (size >= remaining) begin
        size = remaining;
        if (shape == IMG_OVERFLOW) begin
          size = remaining + $urandom_range(1, 6);
          if (size > 128) size = 128;
        end
      end
      send_packet(size, eff, first);
      first = 1'b0;
      remaining -= (size < remaining) ? size : remaining;
    end
    case (shape)
      IMG_TRUNCATED: begin
        push_byte(BYTE_W'($urandom_range(0, 255)), first);
        repeat ($urandom_range(0, eff - 1)) push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
      end
      IMG_OVERFLOW, IMG_TRAILING: begin
        repeat ($urandom_range(1, 3)) push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
      end
      default: ;
    endcase
  endtask

  // New register setting, then a few images under it until the goal is met
  task automatic random_phase(input int unsigned goal);
    logic [BPP_W-1:0]      bpp;
    logic [CFG_DATA_W-1:0] count;
    int unsigned           pick;
    int unsigned           eff;
    pick = $urandom_range(0, 9);
    if (pick < 8) bpp = BPP_W'($urandom_range(1, 4));
    else if (pick == 8) bpp = '0;
    else bpp = BPP_W'($urandom_range(5, 7));
    pick = $urandom_range(0, 19);
    if (pick == 0) count = '0;
    else if (pick == 1) count = '1;
    else if (pick == 2) count = CFG_DATA_W'($urandom_range(151, 24'hFFFFFF));
    else count = CFG_DATA_W'($urandom_range(1, 40));
    eff = (bpp == 0) ? 1 : ((bpp > MAX_BPP_DEF) ? MAX_BPP_DEF : int'(bpp));
    program_regs(bpp, count);
    repeat ($urandom_range(1, 4)) begin
      if (decoded_items < goal) send_image(count, eff);
    end
  endtask

  initial begin
    int unsigned random_goal;
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers: one 3-byte pixel ends the image, next byte ignored
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h3C, 1'b0);

    // Run of 128 while the receiver holds off, sender keeps offering
    program_regs(3'd4, 24'd300);
    hold_requests++;
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h81, 1'b0);
    repeat (4) push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);

    // Overflow in the second slot after the final pixel
    program_regs(3'd1, 24'd3);
    push_byte(8'h83, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hC3, 1'b0);

    // Zero pixel count, size 0 acting as 1
    program_regs(3'd0, 24'd0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h77, 1'b0);

    // Size 7 acting as 4, full count, then size change inside a pixel
    program_regs(3'd7, 24'hFFFFFF);
    push_byte(8'h01, 1'b1);
    repeat (4) push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    program_regs(3'd2, 24'hFFFFFF);
    push_byte(8'h56, 1'b0);

    random_goal = decoded_items + RANDOM_ITEMS;
    while (decoded_items < random_goal) random_phase(random_goal);

    quiesce();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tga_rle_pixel_decoder_top verification clean");
    end else begin
      $display("tga_rle_pixel_decoder_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tgarle_pkg.sv
sv/tgarle_ctrl.sv
sv/tgarle_dp.sv
sv/tga_rle_pixel_decoder_top.sv
bench/tga_rle_sb_pkg.sv
bench/tb_tga_rle_pixel_decoder_top.sv
